>>> rtl/core/kdtl_pkg.sv
// shared types, constants and helpers for the k-nearest-neighbor list unit
package kdtl_pkg;

	localparam int MAX_NEIGHBORS = 16;
	localparam int ID_W          = 16;
	localparam int VAL_W         = 16;
	localparam int SQ_W          = 2 * VAL_W;
	localparam int DIST_W        = 39;
	localparam int RANK_W        = 4;
	localparam int CNT_W         = 5;
	localparam int ACT_W         = 2;

	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACC   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd2;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ACT_W-1:0]  act_t;

	typedef struct packed {
		id_t   id;
		dist_t distance;
		rank_t rank;
		cnt_t  count;
		logic  inserted;
		logic  empty;
		logic  last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic acc_step;
		logic acc_last;
		logic read_start;
		logic read_step;
		logic insert;
		logic emit_clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic read_last;
		cnt_t count;
	} sts_t;

	function automatic cnt_t eff_limit(input cnt_t lim);
		cnt_t k;
		k = lim;
		if (lim == '0) begin
			k = CNT_W'(1);
		end else if (lim > CNT_W'(MAX_NEIGHBORS)) begin
			k = CNT_W'(MAX_NEIGHBORS);
		end
		return k;
	endfunction

endpackage

>>> rtl/core/kdtl_if.sv
// channel interfaces: input items, result items, limit register writes
interface kdtl_in_if;
	logic                valid;
	logic                ready;
	kdtl_pkg::act_t      action;
	kdtl_pkg::id_t       candidate_id;
	kdtl_pkg::val_t      query_value;
	kdtl_pkg::val_t      candidate_value;
	logic                last_element;

	modport source (output valid, action, candidate_id, query_value, candidate_value,
		last_element, input ready);
	modport sink (input valid, action, candidate_id, query_value, candidate_value,
		last_element, output ready);
endinterface

interface kdtl_out_if;
	logic                valid;
	logic                ready;
	kdtl_pkg::id_t       neighbor_id;
	kdtl_pkg::dist_t     neighbor_distance;
	kdtl_pkg::rank_t     neighbor_rank;
	kdtl_pkg::cnt_t      list_count;
	logic                inserted;
	logic                list_empty;
	logic                last_result;

	modport source (output valid, neighbor_id, neighbor_distance, neighbor_rank, list_count,
		inserted, list_empty, last_result, input ready);
	modport sink (input valid, neighbor_id, neighbor_distance, neighbor_rank, list_count,
		inserted, list_empty, last_result, output ready);
endinterface

interface kdtl_cfg_if;
	logic                valid;
	logic                ready;
	kdtl_pkg::cnt_t      neighbor_limit;

	modport source (output valid, neighbor_limit, input ready);
	modport sink (input valid, neighbor_limit, output ready);
endinterface

>>> rtl/core/knn_distance_topk_list_unit.sv
// Squared-distance k-nearest-neighbor list. An accumulate item's squared difference is registered
// when it is taken and added in the next cycle, so a new descriptor element is taken only once
// the last is added, via the square register and the saturating 39-bit accumulator. After the
// last element an insert step compares the sum against all list entries in parallel and shifts
// the list, once the result register is free. A read emits one entry per cycle as results are
// taken, n results for n entries (one when empty); a clear empties the list and emits one result.
// A new item is accepted while a finished result still waits in the output register.
module knn_distance_topk_list_unit (
	input  logic         clk,
	input  logic         arst_n,
	kdtl_in_if.sink      item_in,
	kdtl_out_if.source   result_out,
	kdtl_cfg_if.sink     cfg
);
	import kdtl_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	result_t res;
	logic    res_valid;

	kdtl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_action (item_in.action),
		.in_last   (item_in.last_element),
		.in_ready  (item_in.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kdtl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_id     (item_in.candidate_id),
		.in_query  (item_in.query_value),
		.in_cand   (item_in.candidate_value),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.neighbor_limit),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (result_out.ready)
	);

	assign cfg.ready = 1'b1;

	assign result_out.valid             = res_valid;
	assign result_out.neighbor_id       = res.id;
	assign result_out.neighbor_distance = res.distance;
	assign result_out.neighbor_rank     = res.rank;
	assign result_out.list_count        = res.count;
	assign result_out.inserted          = res.inserted;
	assign result_out.list_empty        = res.empty;
	assign result_out.last_result       = res.last;

	// at most one result load per cycle
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.insert, cmd.read_step, cmd.emit_clear}))
		else $error("more than one result load in a cycle");

	// a result is loaded only into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert || cmd.read_step || cmd.emit_clear) |-> sts.out_free)
		else $error("result loaded over a pending result");

	// list never holds more than its capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CNT_W'(MAX_NEIGHBORS))
		else $error("list count beyond capacity");

	// final read-out result returns the block to taking items
	a_read_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read_step && sts.read_last) |=> item_in.ready)
		else $error("block not ready after final read-out transfer");

endmodule

>>> rtl/core/kdtl_ctrl.sv
// controller state machine sequencing accumulate, insert, read and clear
module kdtl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  kdtl_pkg::act_t  in_action,
	input  logic            in_last,
	output logic            in_ready,
	input  kdtl_pkg::sts_t  sts,
	output kdtl_pkg::cmd_t  cmd
);
	import kdtl_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       last_q;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_action)
						ACT_CLEAR: begin
							cmd.clear = 1'b1;
							state_d   = S_CLR;
						end
						ACT_ACC: begin
							cmd.load = 1'b1;
							state_d  = S_ACC;
						end
						ACT_READ: begin
							cmd.read_start = 1'b1;
							state_d        = S_READ;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ACC: begin
				cmd.acc_step = 1'b1;
				cmd.acc_last = last_q;
				state_d      = last_q ? S_INS : S_IDLE;
			end
			S_INS: begin
				if (sts.out_free) begin
					cmd.insert = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.read_step = 1'b1;
					if (sts.read_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_CLR: begin
				if (sts.out_free) begin
					cmd.emit_clear = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= in_last;
			end
		end
	end

endmodule

>>> rtl/core/kdtl_datapath.sv
// distance accumulator, sorted compare-and-shift list and result register
module kdtl_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  kdtl_pkg::cmd_t    cmd,
	output kdtl_pkg::sts_t    sts,
	input  kdtl_pkg::id_t     in_id,
	input  kdtl_pkg::val_t    in_query,
	input  kdtl_pkg::val_t    in_cand,
	input  logic              cfg_we,
	input  kdtl_pkg::cnt_t    cfg_data,
	output kdtl_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_ready
);
	import kdtl_pkg::*;

	sq_t     sq_s1;
	id_t     id_q;
	dist_t   acc_q;
	dist_t   sum_s2;
	cnt_t    lim_q;
	cnt_t    cnt_q;
	rank_t   rd_idx_q;
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;

	id_t     ids_q  [MAX_NEIGHBORS];
	dist_t   dist_q [MAX_NEIGHBORS];

	val_t                diff;
	logic [DIST_W:0]     acc_sum;
	dist_t               acc_sat;
	cnt_t                k;
	cnt_t                n;
	cnt_t                pos;
	cnt_t                li;
	cnt_t                n_ins;
	logic                drop;
	logic [MAX_NEIGHBORS-1:0] le;
	logic                read_last;
	logic                out_load;
	cnt_t                cfg_k;

	assign diff    = (in_query >= in_cand) ? (in_query - in_cand) : (in_cand - in_query);
	assign acc_sum = {1'b0, acc_q} + (DIST_W + 1)'(sq_s1);
	assign acc_sat = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];

	// insertion position among the first n sorted entries
	always_comb begin
		k = eff_limit(lim_q);
		n = (cnt_q > k) ? k : cnt_q;
		for (int i = 0; i < MAX_NEIGHBORS; i++) begin
			le[i] = (CNT_W'(i) < n) && (dist_q[i] <= sum_s2);
		end
		pos = CNT_W'(MAX_NEIGHBORS);
		for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
			if (!le[i]) begin
				pos = CNT_W'(i);
			end
		end
		drop  = (pos >= k);
		li    = (n < k) ? n : (k - CNT_W'(1));
		n_ins = (n < k) ? (n + CNT_W'(1)) : n;
	end

	assign read_last = (cnt_q == '0) || ((CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q);
	assign out_load  = cmd.insert || cmd.read_step || cmd.emit_clear;
	assign cfg_k     = eff_limit(cfg_data);

	always_comb begin
		res_d = '0;
		if (cmd.insert) begin
			res_d.id       = id_q;
			res_d.distance = sum_s2;
			res_d.rank     = drop ? '0 : pos[RANK_W-1:0];
			res_d.count    = drop ? n : n_ins;
			res_d.inserted = !drop;
			res_d.last     = 1'b1;
		end else if (cmd.read_step) begin
			if (cnt_q == '0) begin
				res_d.empty = 1'b1;
				res_d.last  = 1'b1;
			end else begin
				res_d.id       = ids_q[rd_idx_q];
				res_d.distance = dist_q[rd_idx_q];
				res_d.rank     = rd_idx_q;
				res_d.count    = cnt_q;
				res_d.last     = read_last;
			end
		end else begin
			res_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			lim_q       <= LIMIT_RESET;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				acc_q <= '0;
			end else if (cmd.acc_step) begin
				acc_q <= cmd.acc_last ? '0 : acc_sat;
			end

			if (cfg_we) begin
				lim_q <= cfg_data;
				if (cnt_q > cfg_k) begin
					cnt_q <= cfg_k;
				end
			end else if (cmd.clear) begin
				cnt_q <= '0;
			end else if (cmd.insert && !drop) begin
				cnt_q <= n_ins;
			end

			if (cmd.read_start) begin
				rd_idx_q <= '0;
			end else if (cmd.read_step) begin
				rd_idx_q <= rd_idx_q + RANK_W'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sq_s1 <= diff * diff;
			id_q  <= in_id;
		end
		if (cmd.acc_step) begin
			sum_s2 <= acc_sat;
		end
		if (out_load) begin
			res_q <= res_d;
		end
		if (cmd.insert && !drop) begin
			for (int i = 0; i < MAX_NEIGHBORS; i++) begin
				if (CNT_W'(i) == pos) begin
					ids_q[i]  <= id_q;
					dist_q[i] <= sum_s2;
				end else if (i > 0 && CNT_W'(i) > pos && CNT_W'(i) <= li) begin
					ids_q[i]  <= ids_q[i-1];
					dist_q[i] <= dist_q[i-1];
				end
			end
		end
	end

	assign res           = res_q;
	assign res_valid     = out_valid_q;
	assign sts.out_free  = !out_valid_q || res_ready;
	assign sts.read_last = read_last;
	assign sts.count     = cnt_q;

endmodule
